// File: rtl/grtb_pkg.sv
// Shared types and constants for the grouped repeating timer bank.
// Holds the opcode codes, field widths and the per-slot record layout.
// No dependencies.
package grtb_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned DELTA_W  = 16;
  localparam int unsigned TIME_W   = 24;
  localparam int unsigned REP_W    = 8;
  localparam int unsigned GROUP_W  = 3;
  localparam int unsigned SLOT_W   = 4;

  localparam int unsigned DEF_NUM_TIMERS = 16;
  localparam int unsigned DEF_NUM_GROUPS = 8;

  // Number of group codes the group field can carry.
  localparam int unsigned GROUP_CODES = 1 << GROUP_W;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_CANCEL = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_RESUME = 3'd4,
    OP_CLEAR  = 3'd5
  } op_t;

  // One slot's record as kept in the slot memory.
  typedef struct packed {
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W-1:0]  period;
    logic [REP_W-1:0]   repeats;
    logic               perpetual;
    logic [GROUP_W-1:0] group;
  } timer_rec_t;

  localparam int unsigned REC_W = $bits(timer_rec_t);

  // Outcome of advancing one slot by a tick.
  typedef struct packed {
    logic upd;
    logic expire;
    logic comp;
    logic removed;
  } tick_stat_t;

endpackage

// File: rtl/grtb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the slot record store of the timer bank. No dependencies.
module grtb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/grtb_tick_alu.sv
// Advances one slot record by a tick: saturating add, expiry test and
// repeat countdown. Depends on grtb_pkg.
module grtb_tick_alu (
  input  grtb_pkg::timer_rec_t             rec,
  input  logic [grtb_pkg::DELTA_W-1:0]     delta,
  input  logic                             live,
  input  logic                             notify,
  output grtb_pkg::timer_rec_t             rec_nxt,
  output grtb_pkg::tick_stat_t             stat
);
  import grtb_pkg::*;

  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] elapsed_sat;
  logic              expire;
  logic              comp;

  always_comb begin
    sum         = {1'b0, rec.elapsed} + (TIME_W + 1)'(delta);
    elapsed_sat = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    expire      = live && (elapsed_sat >= rec.period);
    // A count of zero behaves like a count of one.
    comp        = expire && !rec.perpetual && (rec.repeats <= REP_W'(1));

    rec_nxt         = rec;
    rec_nxt.elapsed = expire ? '0 : elapsed_sat;
    if (comp) begin
      rec_nxt.repeats = '0;
    end else if (expire && !rec.perpetual) begin
      rec_nxt.repeats = rec.repeats - REP_W'(1);
    end

    stat.upd     = live;
    stat.expire  = expire;
    stat.comp    = comp;
    stat.removed = comp && notify;
  end

endmodule

// File: rtl/grouped_repeating_timer_bank.sv
// Grouped repeating timer bank: a table of timer slots kept in one RAM.
// Depends on grtb_pkg, grtb_ram and grtb_tick_alu.
//
// Usage: operations enter on the in_ channel (valid/ready) and results
// leave on the out_ channel (valid/ready), one beat per result; the final
// beat for each operation carries out_last. A tick walks the slots in
// ascending order, one slot per cycle while the receiver keeps up, and
// sends a beat for every slot that expires, then a closing beat. A clear
// group also walks the slot RAM and then answers. Create, cancel, pause
// and resume answer from the output register once the operation has
// been registered. The walk over the slot RAM sets the tick rate: one
// slot read per cycle while not stalled, the next slot read overlapping
// the write-back of the current one.
// One operation is handled at a time; in_ready is high whenever the bank
// is idle, also while the last result beat still waits on out_ready.
// When the receiver stalls, the walk halts on the expiring slot and holds
// its state until the beat is taken.
// Reset empties the table, unpauses all groups and sets notify_on_complete.
// The notify_on_complete register is written through cfg_wr_en/cfg_wr_data.
module grouped_repeating_timer_bank #(
  parameter int unsigned NUM_TIMERS = grtb_pkg::DEF_NUM_TIMERS,
  parameter int unsigned NUM_GROUPS = grtb_pkg::DEF_NUM_GROUPS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [grtb_pkg::OP_W-1:0]     in_opcode,
  input  logic [grtb_pkg::DELTA_W-1:0]  in_delta_ms,
  input  logic [grtb_pkg::TIME_W-1:0]   in_duration_ms,
  input  logic [grtb_pkg::REP_W-1:0]    in_repeat_count,
  input  logic                          in_repeat_forever,
  input  logic [grtb_pkg::GROUP_W-1:0]  in_group,
  input  logic [grtb_pkg::SLOT_W-1:0]   in_slot,
  input  logic                          in_notify_removed,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [grtb_pkg::SLOT_W-1:0]   out_slot_index,
  output logic                          out_repeated,
  output logic                          out_completed,
  output logic                          out_removed,
  output logic                          out_accepted,
  output logic                          out_last
);
  import grtb_pkg::*;

  localparam int unsigned IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
  localparam int unsigned SLOT_CMP_W = 7;
  localparam int unsigned GRP_CMP_W  = 9;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_TICK_END,
    ST_CLEAR
  } state_t;

  state_t                state_r;
  logic [IDX_W-1:0]      idx_r;
  logic [NUM_TIMERS-1:0] valid_r;
  logic [NUM_TIMERS-1:0] del_r;
  logic [GROUP_CODES-1:0] paused_r;
  logic                  notify_r;

  op_t                   op_r;
  logic [DELTA_W-1:0]    delta_r;
  logic [TIME_W-1:0]     dur_r;
  logic [REP_W-1:0]      rcnt_r;
  logic                  forever_r;
  logic [GROUP_W-1:0]    grp_r;
  logic [SLOT_W-1:0]     slot_r;
  logic                  notify_rm_r;
  logic                  grp_ok_r;

  logic                  out_valid_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic                  out_rep_r;
  logic                  out_comp_r;
  logic                  out_rem_r;
  logic                  out_acc_r;
  logic                  out_last_r;

  logic                  in_fire;
  logic                  in_grp_ok;
  logic                  out_free;
  logic                  out_load;
  logic                  last_idx;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [REC_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [REC_W-1:0]      ram_rdata;

  timer_rec_t            rd_rec;
  timer_rec_t            alu_rec_nxt;
  timer_rec_t            new_rec;
  tick_stat_t            stat;
  logic                  slot_live;
  logic                  stall;

  logic [IDX_W-1:0]      free_idx;
  logic                  free_any;
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic                  slot_in_rng;
  logic                  cancel_hit;
  logic                  create_ok;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign in_grp_ok = {(GRP_CMP_W - GROUP_W)'(0), in_group} < GRP_CMP_W'(NUM_GROUPS);
  assign out_free  = !out_valid_r || out_ready;
  assign last_idx  = (idx_r == LAST_IDX);

  assign rd_rec    = timer_rec_t'(ram_rdata);
  assign slot_live = valid_r[idx_r] && !del_r[idx_r] && !paused_r[rd_rec.group];
  assign stall     = stat.expire && !out_free;

  // A new result beat enters the output register at this edge.
  assign out_load  = (((state_r == ST_EXEC) || (state_r == ST_TICK_END)) && out_free) ||
                     ((state_r == ST_TICK) && !stall && stat.expire);

  grtb_tick_alu u_alu (
    .rec     (rd_rec),
    .delta   (delta_r),
    .live    (slot_live),
    .notify  (notify_r),
    .rec_nxt (alu_rec_nxt),
    .stat    (stat)
  );

  // Lowest free slot for create.
  always_comb begin
    free_idx = '0;
    for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    free_any = ~&valid_r;
  end

  assign slot_ext    = SLOT_EXT_W'(slot_r);
  assign slot_in_rng = {(SLOT_CMP_W - SLOT_W)'(0), slot_r} < SLOT_CMP_W'(NUM_TIMERS);
  assign cancel_hit  = slot_in_rng && valid_r[slot_ext[IDX_W-1:0]] &&
                       !del_r[slot_ext[IDX_W-1:0]];
  assign create_ok   = grp_ok_r && free_any;

  always_comb begin
    new_rec           = '0;
    new_rec.period    = dur_r;
    new_rec.repeats   = rcnt_r;
    new_rec.perpetual = forever_r;
    new_rec.group     = grp_r;
  end

  // Slot RAM port control. The read of the next slot overlaps the
  // write-back of the current one, so the two addresses always differ.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_r + IDX_W'(1);
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = REC_W'(alu_rec_nxt);
    case (state_r)
      ST_IDLE: begin
        if (in_fire && ((in_opcode == OP_TICK) || ((in_opcode == OP_CLEAR) && in_grp_ok))) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
        end
      end
      ST_TICK: begin
        if (!stall) begin
          ram_we = stat.upd;
          ram_re = !last_idx;
        end
      end
      ST_CLEAR: begin
        ram_re = !last_idx;
      end
      ST_EXEC: begin
        if ((op_r == OP_CREATE) && create_ok && out_free) begin
          ram_we    = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = REC_W'(new_rec);
        end
      end
      default: begin
      end
    endcase
  end

  grtb_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_TIMERS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      del_r       <= '0;
      paused_r    <= '0;
      notify_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        notify_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r        <= op_t'(in_opcode);
            delta_r     <= in_delta_ms;
            dur_r       <= in_duration_ms;
            rcnt_r      <= in_repeat_count;
            forever_r   <= in_repeat_forever;
            grp_r       <= in_group;
            slot_r      <= in_slot;
            notify_rm_r <= in_notify_removed;
            grp_ok_r    <= in_grp_ok;
            idx_r       <= '0;
            if (in_opcode == OP_TICK) begin
              state_r <= ST_TICK;
            end else if ((in_opcode == OP_CLEAR) && in_grp_ok) begin
              state_r <= ST_CLEAR;
            end else begin
              state_r <= ST_EXEC;
            end
          end
        end

        ST_EXEC: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_rep_r   <= 1'b0;
            out_comp_r  <= 1'b0;
            out_last_r  <= 1'b1;
            case (op_r)
              OP_CREATE: begin
                if (create_ok) begin
                  valid_r[free_idx] <= 1'b1;
                  del_r[free_idx]   <= 1'b0;
                end
                out_slot_r <= create_ok ? SLOT_W'(free_idx) : '0;
                out_rem_r  <= 1'b0;
                out_acc_r  <= create_ok;
              end
              OP_CANCEL: begin
                if (cancel_hit) begin
                  del_r[slot_ext[IDX_W-1:0]] <= 1'b1;
                end
                out_slot_r <= slot_r;
                out_rem_r  <= cancel_hit && notify_rm_r;
                out_acc_r  <= cancel_hit;
              end
              OP_PAUSE, OP_RESUME: begin
                if (grp_ok_r) begin
                  paused_r[grp_r] <= (op_r == OP_PAUSE);
                end
                out_slot_r <= '0;
                out_rem_r  <= 1'b0;
                out_acc_r  <= grp_ok_r;
              end
              OP_CLEAR: begin
                out_slot_r <= '0;
                out_rem_r  <= 1'b0;
                out_acc_r  <= grp_ok_r;
              end
              default: begin
                out_slot_r <= '0;
                out_rem_r  <= 1'b0;
                out_acc_r  <= 1'b0;
              end
            endcase
            state_r <= ST_IDLE;
          end
        end

        ST_TICK: begin
          if (!stall) begin
            if (stat.comp) begin
              del_r[idx_r] <= 1'b1;
            end
            if (stat.expire) begin
              out_valid_r <= 1'b1;
              out_slot_r  <= SLOT_W'(idx_r);
              out_rep_r   <= 1'b1;
              out_comp_r  <= stat.comp;
              out_rem_r   <= stat.removed;
              out_acc_r   <= 1'b1;
              out_last_r  <= 1'b0;
            end
            if (last_idx) begin
              state_r <= ST_TICK_END;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end

        ST_TICK_END: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_slot_r  <= '0;
            out_rep_r   <= 1'b0;
            out_comp_r  <= 1'b0;
            out_rem_r   <= 1'b0;
            out_acc_r   <= 1'b1;
            out_last_r  <= 1'b1;
            // Slots marked during this or the previous operations go free now.
            valid_r     <= valid_r & ~del_r;
            del_r       <= '0;
            state_r     <= ST_IDLE;
          end
        end

        ST_CLEAR: begin
          if (valid_r[idx_r] && (rd_rec.group == grp_r)) begin
            valid_r[idx_r] <= 1'b0;
            del_r[idx_r]   <= 1'b0;
          end
          if (last_idx) begin
            state_r <= ST_EXEC;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end

        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_slot_index = out_slot_r;
  assign out_repeated   = out_rep_r;
  assign out_completed  = out_comp_r;
  assign out_removed    = out_rem_r;
  assign out_accepted   = out_acc_r;
  assign out_last       = out_last_r;

  // A write-back and the overlapping read never hit the same slot.
  a_ram_no_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("slot RAM read and write collide");

  // Only live slots can be marked for deletion.
  a_del_subset: assert property (@(posedge clk) disable iff (!rst_n)
    (del_r & ~valid_r) == '0)
    else $error("slot marked for deletion is not valid");

  // The closing beat of a tick frees every marked slot.
  a_tick_frees: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_TICK_END) && out_free) |=> (del_r == '0))
    else $error("marked slots survive the end of a tick");

  // A walk over the slot RAM stays inside the table.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_TICK) || (state_r == ST_CLEAR)) |-> (idx_r <= LAST_IDX))
    else $error("slot walk index out of range");

endmodule
